/* rtl/crarm_pkg.sv */
// ----------------------------------------------------------------------------
// crarm_pkg: shared constants and helpers
// Sizes, action codes and saturating 48-bit arithmetic for the range store.
// ----------------------------------------------------------------------------
package crarm_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int SEG_LEN      = 64;
  localparam int NUM_BLOCKS   = MAX_ELEMENTS / SEG_LEN;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int OFF_W        = $clog2(SEG_LEN);
  localparam int BLK_W        = $clog2(NUM_BLOCKS);
  localparam int LEN_W        = IDX_W + 1;
  localparam int VAL_W        = 48;
  localparam int AMT_W        = 32;
  localparam int ACT_W        = 2;

  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] x,
                                                      input logic signed [VAL_W-1:0] y);
    logic signed [VAL_W:0] s;
    s = {x[VAL_W-1], x} + {y[VAL_W-1], y};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VMIN : VMAX;
    return s[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_sub(input logic signed [VAL_W-1:0] x,
                                                      input logic signed [VAL_W-1:0] y);
    logic signed [VAL_W:0] s;
    s = {x[VAL_W-1], x} - {y[VAL_W-1], y};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VMIN : VMAX;
    return s[VAL_W-1:0];
  endfunction

endpackage

/* rtl/circular_range_add_range_min_core.sv */
// ----------------------------------------------------------------------------
// circular_range_add_range_min_core: block-decomposed range add / range min
// Elements and per-block minimum / pending add live in two synchronous RAMs.
// ----------------------------------------------------------------------------
// Steps: a fully covered block is read, evaluated and passed; a partly covered
//   block is also swept element by element and written back (not for a query).
// Throughput: one request at a time; a wrapped range visits up to 65 blocks,
//   3 partly covered, and a query result waits while the output stalls.
// Reset: a clearing pass over both RAMs, input not ready meanwhile.
module circular_range_add_range_min_core
  import crarm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i,      // used_length
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [55:0]          s_axis_tdata_i,   // first_index, last_index, amount
  input  logic [ACT_W-1:0]     s_axis_tuser_i,   // action
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [VAL_W-1:0]     m_axis_tdata_o    // range_minimum
);

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_BLK_RD   = 8'b0000_0100,
    ST_BLK_EVAL = 8'b0000_1000,
    ST_EL_SCAN  = 8'b0001_0000,
    ST_EL_DRAIN = 8'b0010_0000,
    ST_BLK_WB   = 8'b0100_0000,
    ST_NEXT     = 8'b1000_0000
  } state_e;

  localparam int EW_W = VAL_W + 1;
  localparam int BW_W = 2 * VAL_W + 1;

  state_e                   state_q, state_d;
  logic [LEN_W-1:0]         ulen_q;
  logic [IDX_W-1:0]         clr_q, clr_d;
  action_e                  op_q, op_d;
  logic [IDX_W-1:0]         a_q, a_d, z_q, z_d, l_q, l_d;
  logic                     wrap_q, wrap_d;
  logic [BLK_W-1:0]         blk_q, blk_d;
  logic [OFF_W-1:0]         idx_q, idx_d, roff_q;
  logic                     rdv_q;
  logic signed [VAL_W-1:0]  amt_q, amt_d, pend_q, pend_d, bmin_q, bmin_d, acc_q, acc_d;
  logic                     bld_q, bld_d;
  logic                     ov_q, ov_d;
  logic signed [VAL_W-1:0]  od_q, od_d;

  logic                     ew_en, er_en;
  logic [IDX_W-1:0]         ew_addr, er_addr;
  logic [EW_W-1:0]          ew_data, er_data;
  logic                     bw_en;
  logic [BLK_W-1:0]         bw_addr;
  logic [BW_W-1:0]          bw_data, br_data;

  logic [LEN_W-1:0]         n_len;
  logic [IDX_W-1:0]         nm1, in_f, in_l, cf, cl;
  logic [IDX_W-1:0]         eaddr, bs, be;
  logic                     inr, e_ld, new_ld;
  logic signed [VAL_W-1:0]  e_val, new_val, cand;

  crarm_ram #(.WIDTH(EW_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk_i, .we_i(ew_en), .waddr_i(ew_addr), .wdata_i(ew_data),
    .re_i(er_en), .raddr_i(er_addr), .rdata_o(er_data)
  );

  crarm_ram #(.WIDTH(BW_W), .DEPTH(NUM_BLOCKS)) u_blk_ram (
    .clk_i, .we_i(bw_en), .waddr_i(bw_addr), .wdata_i(bw_data),
    .re_i(state_q == ST_BLK_RD), .raddr_i(blk_q), .rdata_o(br_data)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;

  assign in_f = s_axis_tdata_i[IDX_W-1:0];
  assign in_l = s_axis_tdata_i[2*IDX_W-1:IDX_W];

  always_comb begin
    if (ulen_q == '0) begin
      n_len = LEN_W'(1);
    end else if (ulen_q > LEN_W'(MAX_ELEMENTS)) begin
      n_len = LEN_W'(MAX_ELEMENTS);
    end else begin
      n_len = ulen_q;
    end
  end
  assign nm1 = IDX_W'(n_len - LEN_W'(1));
  assign cf  = ({1'b0, in_f} >= n_len) ? nm1 : in_f;
  assign cl  = ({1'b0, in_l} >= n_len) ? nm1 : in_l;

  assign eaddr = {blk_q, roff_q};
  assign bs    = {blk_q, {OFF_W{1'b0}}};
  assign be    = {blk_q, {OFF_W{1'b1}}};
  assign inr   = (eaddr >= a_q) && (eaddr <= z_q);
  assign e_ld  = er_data[VAL_W];
  assign e_val = er_data[VAL_W-1:0];
  assign cand  = sat_add(e_val, pend_q);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    op_d    = op_q;
    a_d     = a_q;
    z_d     = z_q;
    l_d     = l_q;
    wrap_d  = wrap_q;
    blk_d   = blk_q;
    idx_d   = idx_q;
    amt_d   = amt_q;
    pend_d  = pend_q;
    bmin_d  = bmin_q;
    acc_d   = acc_q;
    bld_d   = bld_q;
    ov_d    = ov_q && !m_axis_tready_i;
    od_d    = od_q;
    ew_en   = 1'b0;
    ew_addr = eaddr;
    ew_data = er_data;
    er_en   = (state_q == ST_EL_SCAN);
    er_addr = {blk_q, idx_q};
    bw_en   = 1'b0;
    bw_addr = blk_q;
    bw_data = {bld_q, pend_q, bmin_q};
    new_ld  = e_ld;
    new_val = e_val;

    if (rdv_q) begin
      unique case (op_q)
        ACT_LOAD: begin
          if (inr) begin
            new_ld  = 1'b1;
            new_val = sat_sub(amt_q, pend_q);
            ew_en   = 1'b1;
          end
        end
        ACT_ADD: begin
          if (inr && e_ld) begin
            new_val = sat_add(e_val, amt_q);
            ew_en   = 1'b1;
          end
        end
        default: begin
          if (inr && e_ld && (cand < acc_q)) acc_d = cand;
        end
      endcase
      ew_data = {new_ld, new_val};
      if (new_ld && (new_val < bmin_q)) bmin_d = new_val;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ew_en   = 1'b1;
        ew_addr = clr_q;
        ew_data = '0;
        bw_en   = 1'b1;
        bw_addr = clr_q[BLK_W-1:0];
        bw_data = {1'b0, {VAL_W{1'b0}}, VMAX};
        clr_d   = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_ELEMENTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d   = action_e'(s_axis_tuser_i);
          amt_d  = VAL_W'(signed'(s_axis_tdata_i[55:2*IDX_W]));
          acc_d  = VMAX;
          l_d    = cl;
          wrap_d = 1'b0;
          unique case (action_e'(s_axis_tuser_i))
            ACT_LOAD: begin
              a_d = in_f;
              z_d = in_f;
              if ({1'b0, in_f} < n_len) state_d = ST_BLK_RD;
            end
            ACT_ADD, ACT_QUERY: begin
              a_d = cf;
              if (cf <= cl) begin
                z_d = cl;
              end else begin
                z_d    = nm1;
                wrap_d = 1'b1;
              end
              state_d = ST_BLK_RD;
            end
            default: ;
          endcase
          blk_d = (action_e'(s_axis_tuser_i) == ACT_LOAD) ? in_f[IDX_W-1:OFF_W]
                                                           : cf[IDX_W-1:OFF_W];
        end
      end
      ST_BLK_RD: state_d = ST_BLK_EVAL;
      ST_BLK_EVAL: begin
        bld_d  = br_data[BW_W-1];
        pend_d = br_data[2*VAL_W-1:VAL_W];
        if ((bs >= a_q) && (be <= z_q)) begin
          state_d = ST_NEXT;
          if (op_q == ACT_ADD) begin
            bw_en   = 1'b1;
            bw_data = {br_data[BW_W-1], sat_add(br_data[2*VAL_W-1:VAL_W], amt_q),
                       br_data[VAL_W-1:0]};
          end else if (br_data[BW_W-1] &&
                       (sat_add(br_data[VAL_W-1:0], br_data[2*VAL_W-1:VAL_W]) < acc_q)) begin
            acc_d = sat_add(br_data[VAL_W-1:0], br_data[2*VAL_W-1:VAL_W]);
          end
        end else begin
          bmin_d  = VMAX;
          idx_d   = '0;
          state_d = ST_EL_SCAN;
        end
      end
      ST_EL_SCAN: begin
        idx_d = idx_q + OFF_W'(1);
        if (idx_q == OFF_W'(SEG_LEN - 1)) state_d = ST_EL_DRAIN;
      end
      ST_EL_DRAIN: state_d = (op_q == ACT_QUERY) ? ST_NEXT : ST_BLK_WB;
      ST_BLK_WB: begin
        bw_en   = 1'b1;
        bw_data = {bld_q || (op_q == ACT_LOAD), pend_q, bmin_q};
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (blk_q != z_q[IDX_W-1:OFF_W]) begin
          blk_d   = blk_q + BLK_W'(1);
          state_d = ST_BLK_RD;
        end else if (wrap_q) begin
          wrap_d  = 1'b0;
          a_d     = '0;
          z_d     = l_q;
          blk_d   = '0;
          state_d = ST_BLK_RD;
        end else if (op_q == ACT_QUERY) begin
          if (!ov_q || m_axis_tready_i) begin
            ov_d    = 1'b1;
            od_d    = acc_q;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ulen_q  <= LEN_W'(MAX_ELEMENTS);
      ov_q    <= 1'b0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      rdv_q   <= (state_q == ST_EL_SCAN);
      if (cfg_we_i) ulen_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    z_q    <= z_d;
    l_q    <= l_d;
    wrap_q <= wrap_d;
    blk_q  <= blk_d;
    idx_q  <= idx_d;
    roff_q <= idx_q;
    amt_q  <= amt_d;
    pend_q <= pend_d;
    bmin_q <= bmin_d;
    acc_q  <= acc_d;
    bld_q  <= bld_d;
    od_q   <= od_d;
  end

  // element read data only arrives during a block sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> (state_q == ST_EL_SCAN || state_q == ST_EL_DRAIN))
    else $error("element data outside sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLK_EVAL) |-> ($past(state_q) == ST_BLK_RD))
    else $error("block entry used without a read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> (clr_q == '0))
    else $error("request taken before clearing pass done");

endmodule

/* rtl/crarm_ram.sv */
// ----------------------------------------------------------------------------
// crarm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crarm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: circular range add / range minimum core
// Loads, range adds (plain and wrapped) and minimum queries are streamed in
// with random gaps and output stalls; a behavioural model of the block-split
// store predicts every query answer, which is checked in order.
// ----------------------------------------------------------------------------
module testbench
  import crarm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    action_e          act;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [AMT_W-1:0] amt;
  } request_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [LEN_W-1:0]   cfg_wdata_i = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [55:0]        s_axis_tdata_i = '0;
  logic [ACT_W-1:0]   s_axis_tuser_i = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [VAL_W-1:0]   m_axis_tdata_o;

  circular_range_add_range_min_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic signed [VAL_W-1:0] elem_val [MAX_ELEMENTS];
  bit                      elem_set [MAX_ELEMENTS];
  logic signed [VAL_W-1:0] blk_min  [NUM_BLOCKS];
  logic signed [VAL_W-1:0] blk_add  [NUM_BLOCKS];
  bit                      blk_set  [NUM_BLOCKS];
  int                      used_len = MAX_ELEMENTS;

  request_t                pending_req [$];
  logic signed [VAL_W-1:0] expected_min [$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_off = 1'b0;
  bit  in_taken = 1'b0;

  function automatic logic signed [VAL_W-1:0] clamp48(longint v);
    if (v > longint'(VMAX)) return VMAX;
    if (v < longint'(VMIN)) return VMIN;
    return v[VAL_W-1:0];
  endfunction

  function automatic void rescan_block(int b);
    logic signed [VAL_W-1:0] m;
    m = VMAX;
    for (int i = b * SEG_LEN; i < (b + 1) * SEG_LEN; i++)
      if (elem_set[i] && elem_val[i] < m) m = elem_val[i];
    blk_min[b] = m;
  endfunction

  function automatic void add_span(int a, int z, longint amt);
    for (int b = a / SEG_LEN; b <= z / SEG_LEN; b++) begin
      int s, e;
      s = b * SEG_LEN;
      e = s + SEG_LEN - 1;
      if (s >= a && e <= z) begin
        blk_add[b] = clamp48(longint'(blk_add[b]) + amt);
      end else begin
        for (int i = (s > a ? s : a); i <= (e < z ? e : z); i++)
          if (elem_set[i]) elem_val[i] = clamp48(longint'(elem_val[i]) + amt);
        rescan_block(b);
      end
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] min_span(int a, int z);
    logic signed [VAL_W-1:0] m, v;
    m = VMAX;
    for (int b = a / SEG_LEN; b <= z / SEG_LEN; b++) begin
      int s, e;
      s = b * SEG_LEN;
      e = s + SEG_LEN - 1;
      if (s >= a && e <= z) begin
        if (blk_set[b]) begin
          v = clamp48(longint'(blk_min[b]) + longint'(blk_add[b]));
          if (v < m) m = v;
        end
      end else begin
        for (int i = (s > a ? s : a); i <= (e < z ? e : z); i++)
          if (elem_set[i]) begin
            v = clamp48(longint'(elem_val[i]) + longint'(blk_add[i / SEG_LEN]));
            if (v < m) m = v;
          end
      end
    end
    return m;
  endfunction

  function automatic void predict_range_min(request_t r);
    int f, l, n, b;
    longint amt;
    logic signed [VAL_W-1:0] m1, m2;
    n = used_len;
    f = r.first;
    l = r.last;
    amt = longint'($signed(r.amt));
    case (r.act)
      ACT_LOAD: begin
        if (f < n) begin
          b = f / SEG_LEN;
          elem_val[f] = clamp48(amt - longint'(blk_add[b]));
          elem_set[f] = 1'b1;
          blk_set[b] = 1'b1;
          rescan_block(b);
        end
      end
      ACT_ADD, ACT_QUERY: begin
        if (f >= n) f = n - 1;
        if (l >= n) l = n - 1;
        if (r.act == ACT_ADD) begin
          if (f <= l) add_span(f, l, amt);
          else begin
            add_span(f, n - 1, amt);
            add_span(0, l, amt);
          end
        end else begin
          if (f <= l) m1 = min_span(f, l);
          else begin
            m1 = min_span(f, n - 1);
            m2 = min_span(0, l);
            if (m2 < m1) m1 = m2;
          end
          expected_min.push_back(m1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver: an offered request stays put until it is taken
  always @(negedge clk_i) begin
    request_t r;
    if (s_axis_tvalid_i && !in_taken) begin
      s_axis_tvalid_i <= 1'b1;
    end else if (pending_req.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
      r = pending_req[0];
      s_axis_tvalid_i <= 1'b1;
      s_axis_tuser_i  <= r.act;
      s_axis_tdata_i  <= {r.amt, r.last, r.first};
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
    m_axis_tready_i <= !hold_off && (quiet || $urandom_range(99) >= 12);
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (s_axis_tvalid_i && s_axis_tready_o)
      predict_range_min(pending_req.pop_front());
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_min.size() == 0)
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata_o));
      else if (m_axis_tdata_o !== expected_min[0])
        report_mismatch($sformatf("range_minimum %h, want %h", m_axis_tdata_o,
                                  expected_min.pop_front()));
      else
        void'(expected_min.pop_front());
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 3_000_000) begin
      $display("circular_range_add_range_min_core: mismatch");
      $finish;
    end
  end

  task automatic push_req(action_e a, int f, int l, logic [AMT_W-1:0] amt);
    request_t r;
    r.act = a;
    r.first = f[IDX_W-1:0];
    r.last = l[IDX_W-1:0];
    r.amt = amt;
    pending_req.push_back(r);
  endtask

  task automatic drain();
    while (pending_req.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_min.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic set_length(int n);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[LEN_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    used_len = (n < 1) ? 1 : (n > MAX_ELEMENTS ? MAX_ELEMENTS : n);
  endtask

  function automatic int pick_index(int n);
    int k;
    k = $urandom_range(99);
    if (k < 6) return $urandom_range(4095);
    if (k < 12) return (k & 1) ? 0 : n - 1;
    if (k < 20) return (($urandom_range(n - 1) / SEG_LEN) * SEG_LEN
                        + ((k & 1) ? SEG_LEN - 1 : 0)) % n;
    return $urandom_range(n - 1);
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      3, 4: return $urandom_range(200) - 100;
      default: return $urandom_range(2000000) - 1000000;
    endcase
  endfunction

  task automatic random_phase(int count, int n);
    for (int i = 0; i < count; i++) begin
      int k;
      k = $urandom_range(99);
      if (k < 35)
        push_req(ACT_LOAD, ($urandom_range(9) == 0) ? $urandom_range(4095)
                 : $urandom_range(n - 1), 0, pick_amount());
      else if (k < 65)
        push_req(ACT_ADD, pick_index(n), pick_index(n), pick_amount());
      else if (k < 97)
        push_req(ACT_QUERY, pick_index(n), pick_index(n), $urandom());
      else
        push_req(ACT_NONE, $urandom_range(4095), $urandom_range(4095), $urandom());
    end
  endtask

  initial begin
    int lens [6] = '{4096, 100, 1, 8191, 0, 777};
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      elem_val[i] = '0;
      elem_set[i] = 1'b0;
    end
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      blk_min[b] = VMAX;
      blk_add[b] = '0;
      blk_set[b] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    push_req(ACT_QUERY, 0, 4095, '0);
    push_req(ACT_LOAD, 0, 0, 32'h8000_0000);
    push_req(ACT_LOAD, 4095, 0, 32'h7fff_ffff);
    push_req(ACT_LOAD, 63, 0, 32'd5);
    push_req(ACT_LOAD, 64, 0, -32'sd7);
    push_req(ACT_QUERY, 4095, 0, '0);
    push_req(ACT_QUERY, 1, 62, '0);
    push_req(ACT_ADD, 0, 4095, 32'h8000_0000);
    push_req(ACT_ADD, 4000, 100, 32'h7fff_ffff);
    push_req(ACT_LOAD, 65, 0, 32'd9);
    push_req(ACT_QUERY, 0, 127, '0);
    push_req(ACT_QUERY, 4095, 4095, '0);
    push_req(ACT_NONE, 4095, 4095, 32'hffff_ffff);
    for (int i = 0; i < 70; i++) push_req(ACT_ADD, 10, 4095, 32'h8000_0000);
    push_req(ACT_QUERY, 0, 4095, '0);
    for (int i = 0; i < 140; i++) push_req(ACT_ADD, 0, 4095, 32'h7fff_ffff);
    push_req(ACT_QUERY, 0, 4095, '0);
    drain();

    // long receiver hold-off with the sender still busy
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    random_phase(40, used_len);
    wait (!hold_off);
    drain();

    foreach (lens[j]) begin
      set_length(lens[j]);
      quiet = (j == 1);
      push_req(ACT_LOAD, 4095, 0, 32'd3);
      push_req(ACT_QUERY, 4095, 4095, '0);
      push_req(ACT_ADD, 4095, 0, 32'd1);
      push_req(ACT_QUERY, used_len - 1, 0, '0);
      random_phase(280, used_len);
      drain();
    end
    quiet = 1'b0;
    set_length(MAX_ELEMENTS);
    if (errors == 0)
      $display("circular_range_add_range_min_core: match");
    else
      $display("circular_range_add_range_min_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/crarm_pkg.sv
rtl/crarm_ram.sv
rtl/circular_range_add_range_min_core.sv
test/testbench.sv
